// ===== rtl/cpfw_pkg.sv =====
// cpfw_pkg: shared types, constants and codes of the credit pool with fifo wait line
// no dependencies; imported by cpfw_ctrl, cpfw_dp and the top level
package cpfw_pkg;

    // wait line geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LIM_W       = (CNT_W > 4) ? CNT_W : 4;

    // field widths
    localparam int UNIT_W  = 8;
    localparam int ID_W    = 8;
    localparam int LIMIT_W = 4;
    localparam int ENTRY_W = ID_W + UNIT_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 2'd1;

    // reset values
    localparam logic [UNIT_W-1:0]  POOL_RESET  = 8'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd5;

    // request kinds on s_tuser
    localparam logic REQ_TAKE   = 1'b0;
    localparam logic REQ_RETURN = 1'b1;

    // result events
    typedef enum logic [2:0] {
        EV_GRANT   = 3'd0,
        EV_QUEUED  = 3'd1,
        EV_REJECT  = 3'd2,
        EV_DEQUEUE = 3'd3,
        EV_RETURN  = 3'd4
    } cpfw_event_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_READ
    } cpfw_state_t;

    // controller to datapath
    typedef struct packed {
        logic in_load;
        logic req_exec;
        logic ret_exec;
        logic head_emit;
    } cpfw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_is_ret;
        logic out_free;
        logic head_fits;
    } cpfw_stat_t;

endpackage

// ===== rtl/cpfw_ram.sv =====
// cpfw_ram: generic single write port ram with registered read
// no dependencies
module cpfw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cpfw_ctrl.sv =====
// cpfw_ctrl: sequencer for requests, returns and the head grant walk
// depends on cpfw_pkg
module cpfw_ctrl
    import cpfw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  cpfw_stat_t stat,
    output cpfw_cmd_t  cmd
);

    cpfw_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // a return reads the head ram during this cycle
                if (stat.in_is_ret) begin
                    cmd.ret_exec = 1'b1;
                    state_next   = ST_CHECK;
                end else if (stat.out_free) begin
                    cmd.req_exec = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (stat.out_free) begin
                    cmd.head_emit = 1'b1;
                    state_next    = stat.head_fits ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                // new head address settles into the ram read register
                state_next = ST_CHECK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cpfw_dp.sv =====
// cpfw_dp: free count, wait line pointers, ram, configuration and result register
// depends on cpfw_pkg and cpfw_ram
module cpfw_dp
    import cpfw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cpfw_cmd_t             cmd,
    output cpfw_stat_t            stat,
    input  logic                  in_type,
    input  logic [ID_W-1:0]       in_id,
    input  logic [UNIT_W-1:0]     in_amt,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cpfw_event_t           out_event,
    output logic [ID_W-1:0]       out_who,
    output logic [UNIT_W-1:0]     out_units,
    output logic [UNIT_W-1:0]     out_free_units,
    output logic                  out_last
);

    // configuration and pool state
    logic [UNIT_W-1:0]  pool_reg, pool_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [UNIT_W-1:0]  free_reg, free_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // captured request
    logic              in_type_reg, in_type_next;
    logic [ID_W-1:0]   in_id_reg, in_id_next;
    logic [UNIT_W-1:0] in_amt_reg, in_amt_next;

    // result held back until the next head is known
    cpfw_event_t       pend_ev_reg, pend_ev_next;
    logic [ID_W-1:0]   pend_who_reg, pend_who_next;
    logic [UNIT_W-1:0] pend_units_reg, pend_units_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    cpfw_event_t       out_ev_reg, out_ev_next;
    logic [ID_W-1:0]   out_who_reg, out_who_next;
    logic [UNIT_W-1:0] out_units_reg, out_units_next;
    logic [UNIT_W-1:0] out_free_reg, out_free_next;
    logic              out_last_reg, out_last_next;

    // wait line ram
    logic               wr_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [ID_W-1:0]    head_id;
    logic [UNIT_W-1:0]  head_amt;

    // decision helpers
    logic [LIM_W-1:0]  limit_ext;
    logic [LIM_W-1:0]  limit_eff;
    logic [UNIT_W:0]   ret_sum;
    logic [UNIT_W-1:0] ret_free;
    logic              head_fits;
    logic              out_slot_free;

    cpfw_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_wait_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(tail_reg),
        .wr_data({in_amt_reg, in_id_reg}),
        .rd_addr(head_reg),
        .rd_data(rd_data)
    );

    assign head_id  = rd_data[ID_W-1:0];
    assign head_amt = rd_data[ENTRY_W-1:ID_W];

    // effective limit is capped at the line depth
    assign limit_ext = LIM_W'(limit_reg);
    assign limit_eff = (limit_ext < LIM_W'(QUEUE_DEPTH)) ? limit_ext : LIM_W'(QUEUE_DEPTH);

    // saturating return
    assign ret_sum  = {1'b0, free_reg} + {1'b0, in_amt_reg};
    assign ret_free = (ret_sum > {1'b0, pool_reg}) ? pool_reg : ret_sum[UNIT_W-1:0];

    assign head_fits     = (count_reg != '0) && (head_amt <= free_reg);
    assign out_slot_free = !out_valid_reg || out_ready;

    assign stat.in_is_ret = (in_type_reg == REQ_RETURN);
    assign stat.out_free  = out_slot_free;
    assign stat.head_fits = head_fits;

    // next state of the datapath
    always_comb begin
        pool_next       = pool_reg;
        limit_next      = limit_reg;
        free_next       = free_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        in_type_next    = in_type_reg;
        in_id_next      = in_id_reg;
        in_amt_next     = in_amt_reg;
        pend_ev_next    = pend_ev_reg;
        pend_who_next   = pend_who_reg;
        pend_units_next = pend_units_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_ev_next     = out_ev_reg;
        out_who_next    = out_who_reg;
        out_units_next  = out_units_reg;
        out_free_next   = out_free_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;

        // capture request
        if (cmd.in_load) begin
            in_type_next = in_type;
            in_id_next   = in_id;
            in_amt_next  = in_amt;
        end

        // take units: grant, queue or reject
        if (cmd.req_exec) begin
            out_valid_next = 1'b1;
            out_who_next   = in_id_reg;
            out_units_next = in_amt_reg;
            out_last_next  = 1'b1;
            if (in_amt_reg <= free_reg) begin
                free_next   = free_reg - in_amt_reg;
                out_ev_next = EV_GRANT;
            end else if (LIM_W'(count_reg) < limit_eff) begin
                wr_en       = 1'b1;
                tail_next   = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                count_next  = count_reg + 1'b1;
                out_ev_next = EV_QUEUED;
            end else begin
                out_ev_next = EV_REJECT;
            end
            out_free_next = free_next;
        end

        // return units, hold the return event back
        if (cmd.ret_exec) begin
            free_next       = ret_free;
            pend_ev_next    = EV_RETURN;
            pend_who_next   = in_id_reg;
            pend_units_next = in_amt_reg;
        end

        // emit held event, grant the head if it fits
        if (cmd.head_emit) begin
            out_valid_next = 1'b1;
            out_ev_next    = pend_ev_reg;
            out_who_next   = pend_who_reg;
            out_units_next = pend_units_reg;
            out_free_next  = free_reg;
            out_last_next  = !head_fits;
            if (head_fits) begin
                free_next       = free_reg - head_amt;
                head_next       = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next      = count_reg - 1'b1;
                pend_ev_next    = EV_DEQUEUE;
                pend_who_next   = head_id;
                pend_units_next = head_amt;
            end
        end

        // configuration writes; the user is to issue them only while idle, the block itself does not enforce it
        if (cfg_wr) begin
            case (cfg_index)
                CFG_POOL_SIZE: begin
                    pool_next = cfg_data[UNIT_W-1:0];
                    free_next = cfg_data[UNIT_W-1:0];
                end
                CFG_QUEUE_LIMIT: begin
                    limit_next = cfg_data[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg      <= POOL_RESET;
            limit_reg     <= LIMIT_RESET;
            free_reg      <= POOL_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pool_reg      <= pool_next;
            limit_reg     <= limit_next;
            free_reg      <= free_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_type_reg    <= in_type_next;
        in_id_reg      <= in_id_next;
        in_amt_reg     <= in_amt_next;
        pend_ev_reg    <= pend_ev_next;
        pend_who_reg   <= pend_who_next;
        pend_units_reg <= pend_units_next;
        out_ev_reg     <= out_ev_next;
        out_who_reg    <= out_who_next;
        out_units_reg  <= out_units_next;
        out_free_reg   <= out_free_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_event      = out_ev_reg;
    assign out_who        = out_who_reg;
    assign out_units      = out_units_reg;
    assign out_free_units = out_free_reg;
    assign out_last       = out_last_reg;

endmodule

// ===== rtl/credit_pool_fifo_waitline_core.sv =====
// credit_pool_fifo_waitline_core: top level of the credit pool with fifo wait line
// depends on cpfw_pkg, cpfw_ctrl, cpfw_dp and cpfw_ram
//
// Hands out units from a pool of pool_size. A take request (s_tuser 0) is granted at
// once when it fits in the free units, otherwise it joins a wait line of up to
// QUEUE_DEPTH entries (bounded further by queue_limit) or is rejected; it gives one
// result. A return (s_tuser 1) adds its units back, saturating at pool_size, and gives
// a return event followed by one event per waiting head that now fits, in line order;
// m_tlast marks the final result of each request. A take request passes ST_IDLE and
// ST_EXEC; a return ST_IDLE, ST_EXEC and ST_CHECK, plus ST_READ and ST_CHECK per head
// granted, each head check waiting for the wait line ram's registered read. One result
// may wait in the output register while the next request is taken in. Configuration
// writes are taken every cycle and are meant to be issued only while the block is idle.
module credit_pool_fifo_waitline_core
    import cpfw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // requester[7:0], amount[15:8]
    input  logic [0:0]            s_tuser,   // req_type[0]
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // who[7:0], units[15:8], free_units[23:16]
    output logic [2:0]            m_tuser,   // event_res[2:0]
    output logic                  m_tlast,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cpfw_cmd_t         cmd;
    cpfw_stat_t        stat;
    cpfw_event_t       out_event;
    logic [ID_W-1:0]   out_who;
    logic [UNIT_W-1:0] out_units;
    logic [UNIT_W-1:0] out_free_units;

    assign cfg_ready = 1'b1;

    cpfw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cpfw_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_type       (s_tuser[0]),
        .in_id         (s_tdata[7:0]),
        .in_amt        (s_tdata[15:8]),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_event     (out_event),
        .out_who       (out_who),
        .out_units     (out_units),
        .out_free_units(out_free_units),
        .out_last      (m_tlast)
    );

    // result packing
    assign m_tdata = {out_free_units, out_units, out_who};
    assign m_tuser = out_event;

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.in_load, cmd.req_exec, cmd.ret_exec, cmd.head_emit}))
        else $error("controller issued more than one command");

    // results only go into a free output slot
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.req_exec || cmd.head_emit) |-> stat.out_free)
        else $error("result loaded over an unaccepted result");

    // a request in flight blocks new requests
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new request taken while one is in flight");

    // a granted head is always followed by a further result
    a_head_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.head_emit && stat.head_fits) |=> (m_tvalid && !m_tlast))
        else $error("last flag set while a head grant is pending");

endmodule

// ===== tb/credit_pool_fifo_waitline_core_tb.sv =====
// credit_pool_fifo_waitline_core_tb: self-checking bench for the credit pool with fifo wait line
// depends on cpfw_pkg and credit_pool_fifo_waitline_core; a directed table, then random
// phases over several register settings, results checked by table row or in-bench predictor
module credit_pool_fifo_waitline_core_tb;
    import cpfw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int N_ROWS        = 30;
    localparam int N_PHASES      = 7;
    localparam int PHASE_ITEMS   = 44;

    typedef enum logic [1:0] {
        ROW_TAKE,
        ROW_RETURN,
        ROW_WRITE
    } row_kind_t;

    // one expected result
    typedef struct packed {
        cpfw_event_t ev;
        logic [7:0]  who;
        logic [7:0]  units;
        logic [7:0]  free;
        logic        last;
    } result_t;

    // one line of the directed part; a holds id or register index, b amount or value
    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  a;
        logic [7:0]  b;
        logic        typed;
        cpfw_event_t ev;
        logic [7:0]  units;
        logic [7:0]  free;
    } row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // requester[7:0], amount[15:8]
    logic [0:0]            s_tuser;   // req_type[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // who[7:0], units[15:8], free_units[23:16]
    logic [2:0]            m_tuser;   // event_res[2:0]
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    int         pool_sz;
    int         lim_reg;
    int         free_cnt;
    logic [7:0] line_id  [QUEUE_DEPTH];
    logic [7:0] line_amt [QUEUE_DEPTH];
    int         line_head;
    int         line_tail;
    int         line_count;

    result_t pending_events[$];
    bit      failed;
    int      send_idle;
    int      recv_idle;
    int      hold_ask;
    int      hold_left;
    int      stall_cycles;

    row_t directed_rows [N_ROWS] = '{
        '{ROW_TAKE,   8'h00, 8'd0,   1'b1, EV_GRANT,  8'd0,   8'd10},
        '{ROW_TAKE,   8'hFF, 8'd10,  1'b1, EV_GRANT,  8'd10,  8'd0},
        '{ROW_RETURN, 8'h01, 8'd255, 1'b1, EV_RETURN, 8'd255, 8'd10},
        '{ROW_TAKE,   8'hAA, 8'd255, 1'b1, EV_QUEUED, 8'd255, 8'd10},
        '{ROW_TAKE,   8'h55, 8'd3,   1'b1, EV_GRANT,  8'd3,   8'd7},
        '{ROW_TAKE,   8'h10, 8'd8,   1'b0, EV_GRANT,  8'd0,   8'd0},
        '{ROW_TAKE,   8'h11, 8'd9,   1'b0, EV_GRANT,  8'd0,   8'd0},
        '{ROW_TAKE,   8'h12, 8'd9,   1'b0, EV_GRANT,  8'd0,   8'd0},
        '{ROW_TAKE,   8'h13, 8'd9,   1'b0, EV_GRANT,  8'd0,   8'd0},
        '{ROW_TAKE,   8'h14, 8'd200, 1'b1, EV_REJECT, 8'd200, 8'd7},
        '{ROW_RETURN, 8'h20, 8'd3,   1'b1, EV_RETURN, 8'd3,   8'd10},
        '{ROW_WRITE,  8'(CFG_POOL_SIZE),   8'd255, 1'b0, EV_GRANT, 8'd0, 8'd0},
        '{ROW_RETURN, 8'h21, 8'd0,   1'b0, EV_GRANT,  8'd0,   8'd0},
        '{ROW_RETURN, 8'h22, 8'd255, 1'b0, EV_GRANT,  8'd0,   8'd0},
        '{ROW_WRITE,  8'(CFG_QUEUE_LIMIT), 8'd15,  1'b0, EV_GRANT, 8'd0, 8'd0},
        '{ROW_WRITE,  8'(CFG_POOL_SIZE),   8'd0,   1'b0, EV_GRANT, 8'd0, 8'd0},
        '{ROW_TAKE,   8'h80, 8'd1,   1'b1, EV_QUEUED, 8'd1,   8'd0},
        '{ROW_TAKE,   8'h41, 8'd1,   1'b1, EV_QUEUED, 8'd1,   8'd0},
        '{ROW_TAKE,   8'h22, 8'd1,   1'b1, EV_QUEUED, 8'd1,   8'd0},
        '{ROW_TAKE,   8'h0F, 8'd1,   1'b1, EV_QUEUED, 8'd1,   8'd0},
        '{ROW_TAKE,   8'hF0, 8'd1,   1'b1, EV_QUEUED, 8'd1,   8'd0},
        '{ROW_TAKE,   8'h3C, 8'd1,   1'b1, EV_QUEUED, 8'd1,   8'd0},
        '{ROW_TAKE,   8'h5A, 8'd1,   1'b1, EV_QUEUED, 8'd1,   8'd0},
        '{ROW_TAKE,   8'hA5, 8'd1,   1'b1, EV_QUEUED, 8'd1,   8'd0},
        '{ROW_TAKE,   8'hC3, 8'd1,   1'b1, EV_REJECT, 8'd1,   8'd0},
        '{ROW_WRITE,  8'(CFG_POOL_SIZE),   8'd255, 1'b0, EV_GRANT, 8'd0, 8'd0},
        '{ROW_TAKE,   8'h77, 8'd255, 1'b1, EV_GRANT,  8'd255, 8'd0},
        '{ROW_RETURN, 8'h78, 8'd8,   1'b0, EV_GRANT,  8'd0,   8'd0},
        '{ROW_WRITE,  8'(CFG_QUEUE_LIMIT), 8'd0,   1'b0, EV_GRANT, 8'd0, 8'd0},
        '{ROW_TAKE,   8'h99, 8'd1,   1'b1, EV_REJECT, 8'd1,   8'd0}
    };

    // register settings of the random phases
    int phase_pool  [N_PHASES] = '{10, 255, 1, 37, 0, 128, 64};
    int phase_limit [N_PHASES] = '{5, 8, 2, 15, 1, 3, 8};

    credit_pool_fifo_waitline_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // pool bookkeeping for one request, results appended in order
    function automatic void pool_step(input logic is_ret, input logic [7:0] id,
                                      input logic [7:0] amt, ref result_t outs[$]);
        int eff_lim;
        int sum;
        result_t r;
        eff_lim = (lim_reg < QUEUE_DEPTH) ? lim_reg : QUEUE_DEPTH;
        if (is_ret == REQ_TAKE) begin
            if (amt <= free_cnt) begin
                free_cnt -= amt;
                r.ev = EV_GRANT;
            end else if (line_count < eff_lim) begin
                line_id[line_tail]  = id;
                line_amt[line_tail] = amt;
                line_tail  = (line_tail + 1) % QUEUE_DEPTH;
                line_count++;
                r.ev = EV_QUEUED;
            end else begin
                r.ev = EV_REJECT;
            end
            r.who = id;
            r.units = amt;
            r.free = free_cnt[7:0];
            r.last = 1'b0;
            outs.push_back(r);
        end else begin
            sum = free_cnt + amt;
            free_cnt = (sum > pool_sz) ? pool_sz : sum;
            r = '{EV_RETURN, id, amt, free_cnt[7:0], 1'b0};
            outs.push_back(r);
            // grant waiting heads while they fit
            while (line_count > 0 && line_amt[line_head] <= free_cnt) begin
                free_cnt -= line_amt[line_head];
                r = '{EV_DEQUEUE, line_id[line_head], line_amt[line_head], free_cnt[7:0], 1'b0};
                outs.push_back(r);
                line_head = (line_head + 1) % QUEUE_DEPTH;
                line_count--;
            end
        end
        outs[outs.size()-1].last = 1'b1;
    endfunction

    // offer one request and record what it should produce once taken
    task automatic offer_request(input logic is_ret, input logic [7:0] id,
                                 input logic [7:0] amt, input logic typed,
                                 input result_t typed_res);
        result_t got[$];
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_ret;
        s_tdata  <= {amt, id};
        do @(posedge aclk); while (!s_tready);
        pool_step(is_ret, id, amt, got);
        if (typed)
            pending_events.push_back(typed_res);
        else
            foreach (got[i]) pending_events.push_back(got[i]);
    endtask

    // stop sending and wait until the block has gone quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_POOL_SIZE) begin
            pool_sz  = val;
            free_cnt = val;
        end else if (idx == CFG_QUEUE_LIMIT) begin
            lim_reg = val[LIMIT_W-1:0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus long hold-offs on demand
    always @(negedge aclk) begin
        if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result checking against the oldest pending event
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("result with nothing pending: event %0d who %0d units %0d",
                       m_tuser, m_tdata[7:0], m_tdata[15:8]);
                failed = 1'b1;
            end else begin
                want = pending_events.pop_front();
                if (m_tuser !== want.ev) begin
                    $error("event_res: expected %0d, got %0d", want.ev, m_tuser);
                    failed = 1'b1;
                end
                if (m_tdata[7:0] !== want.who) begin
                    $error("who: expected %0d, got %0d", want.who, m_tdata[7:0]);
                    failed = 1'b1;
                end
                if (m_tdata[15:8] !== want.units) begin
                    $error("units: expected %0d, got %0d", want.units, m_tdata[15:8]);
                    failed = 1'b1;
                end
                if (m_tdata[23:16] !== want.free) begin
                    $error("free_units: expected %0d, got %0d", want.free, m_tdata[23:16]);
                    failed = 1'b1;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus
    initial begin
        logic       is_ret;
        logic [7:0] id;
        logic [7:0] amt;
        int         cap;
        row_t       row;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        failed    = 1'b0;
        hold_ask  = 0;
        hold_left = 0;
        stall_cycles = 0;
        send_idle = 15;
        recv_idle = 58;
        pool_sz    = POOL_RESET;
        lim_reg    = LIMIT_RESET;
        free_cnt   = POOL_RESET;
        line_head  = 0;
        line_tail  = 0;
        line_count = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
                write_reg(row.a[CFG_IDX_W-1:0], row.b);
            else
                offer_request((row.kind == ROW_RETURN) ? REQ_RETURN : REQ_TAKE, row.a, row.b,
                              row.typed, '{row.ev, row.a, row.units, row.free, 1'b1});
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(CFG_POOL_SIZE, 8'(phase_pool[ph]));
            write_reg(CFG_QUEUE_LIMIT, 8'(phase_limit[ph]));
            if (ph < 2) begin
                send_idle = 15;
                recv_idle = 58;
            end else if (ph < 4) begin
                send_idle = 58;
                recv_idle = 15;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // long receiver hold-off while requests keep coming
                if ((ph == 1 && k == 10) || (ph == 5 && k == 5))
                    hold_ask = 150;
                // sender waits for every pending result
                if (ph == 3 && k == 20)
                    settle();
                is_ret = ($urandom_range(99) < 55) ? REQ_TAKE : REQ_RETURN;
                id     = 8'($urandom_range(255));
                cap    = (is_ret == REQ_TAKE) ? phase_pool[ph] / 3 : phase_pool[ph] / 2;
                if (cap < 1)
                    cap = 1;
                if ($urandom_range(99) < 10)
                    amt = 8'($urandom_range(255));
                else
                    amt = 8'($urandom_range(cap));
                offer_request(is_ret, id, amt, 1'b0, '0);
            end
        end

        settle();
        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
